// ===== sv/bcrr_pkg.sv =====
// Shared types, codes and saturating Q16.16 helpers for the block-CSR row reducer.
// Depends on nothing; the front end, back end, top level and testbench import it.
`default_nettype none

package bcrr_pkg;

  // Largest block edge supported by default; the top level hands it down as MaxBlock.
  localparam int MAX_BLOCK = 4;

  // Entries in the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes (word offsets on the register port).
  localparam logic [1:0] REG_BLK_ROWS = 2'd0;
  localparam logic [1:0] REG_BLK_COLS = 2'd1;
  localparam logic [1:0] REG_MODE     = 2'd2;

  // Reset values of the registers.
  localparam logic [2:0] BLK_ROWS_RST = 3'd1;
  localparam logic [2:0] BLK_COLS_RST = 3'd1;

  typedef enum logic [1:0] {
    MODE_SUM     = 2'd0,
    MODE_ABS_SUM = 2'd1,
    MODE_MAX_ABS = 2'd2,
    MODE_MAX_ALT = 2'd3
  } mode_e;

  typedef enum logic {
    OP_ELEM   = 1'b0,
    OP_FINISH = 1'b1
  } opcode_e;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Add two Q16.16 values, clamping to the signed 32-bit range.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      sat_add = s[32] ? Q_MIN : Q_MAX;
    end else begin
      sat_add = s[31:0];
    end
  endfunction

  // Absolute value; the most negative value maps to the most positive one.
  function automatic logic signed [31:0] sat_abs(input logic signed [31:0] a);
    if (a == Q_MIN) begin
      sat_abs = Q_MAX;
    end else if (a < 0) begin
      sat_abs = -a;
    end else begin
      sat_abs = a;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/bcrr_fifo.sv =====
// Small register-based first-in first-out queue between the front and the back.
// Depends on nothing beyond its own parameters.
`default_nettype none

module bcrr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output logic [Width-1:0] pop_data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bcrr_front.sv =====
// Front end: accepts input beats, tracks the in-block row position and tags each
// item with its target lane before it enters the queue. Uses bcrr_pkg.
`default_nettype none

module bcrr_front #(
  parameter int MaxBlock = 4,
  parameter int LaneW    = 2
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [2:0]                blk_rows_i,
  input  logic                      blk_rows_wr_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      opcode_i,
  input  logic signed [31:0]        value_i,
  input  logic [1:0]                lane_i,
  input  logic                      q_full_i,
  output logic                      q_push_o,
  output logic [LaneW+35:0]         q_data_o
);
  import bcrr_pkg::*;

  localparam int CntW  = LaneW + 1;
  localparam int LaneX = (LaneW > 2) ? LaneW : 2;

  typedef struct packed {
    logic               elem;
    logic               hit;
    logic [LaneW-1:0]   idx;
    logic [1:0]         lane;
    logic signed [31:0] value;
  } item_t;

  item_t            item;
  logic [LaneW-1:0] pos_q, pos_d;
  logic [LaneW-1:0] cur_pos;
  logic [CntW-1:0]  lanes;
  logic [CntW-1:0]  pos_inc;
  logic [LaneX-1:0] lane_ext;
  logic             accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // Number of lanes in use, with out-of-range block sizes clamped.
  always_comb begin
    if (blk_rows_i == '0) begin
      lanes = CntW'(1);
    end else if (32'(blk_rows_i) > 32'(MaxBlock)) begin
      lanes = CntW'(MaxBlock);
    end else begin
      lanes = CntW'(blk_rows_i);
    end
  end

  assign cur_pos  = (CntW'(pos_q) >= lanes) ? '0 : pos_q;
  assign pos_inc  = CntW'(cur_pos) + CntW'(1);
  assign lane_ext = LaneX'(lane_i);

  always_comb begin
    item.elem  = (opcode_i == OP_ELEM);
    item.value = value_i;
    item.lane  = lane_i;
    if (opcode_i == OP_ELEM) begin
      item.hit = 1'b1;
      item.idx = cur_pos;
    end else begin
      item.hit = (32'(lane_i) < 32'(MaxBlock));
      item.idx = lane_ext[LaneW-1:0];
    end
  end

  assign q_data_o = item;

  always_comb begin
    pos_d = pos_q;
    if (blk_rows_wr_i) begin
      pos_d = '0;
    end else if (accept) begin
      if (opcode_i == OP_ELEM) begin
        pos_d = (pos_inc >= lanes) ? '0 : pos_inc[LaneW-1:0];
      end else begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bcrr_back.sv =====
// Back end: merges queued elements into the lane accumulators and answers finish
// items through a registered output beat. Uses bcrr_pkg.
`default_nettype none

module bcrr_back #(
  parameter int MaxBlock = 4,
  parameter int LaneW    = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         mode_i,
  input  logic               q_valid_i,
  input  logic [LaneW+35:0]  q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] row_result_o,
  output logic [1:0]         lane_out_o
);
  import bcrr_pkg::*;

  typedef struct packed {
    logic               elem;
    logic               hit;
    logic [LaneW-1:0]   idx;
    logic [1:0]         lane;
    logic signed [31:0] value;
  } item_t;

  item_t              item;
  logic signed [31:0] acc_q [MaxBlock];
  logic signed [31:0] acc_rd;
  logic signed [31:0] acc_new;
  logic signed [31:0] abs_v;
  logic signed [31:0] result;
  logic               use_max;
  logic               pop;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] row_result_q;
  logic [1:0]         lane_out_q;

  assign item    = q_data_i;
  assign use_max = mode_i[1];

  // Elements never produce a beat, so they drain even while the output waits.
  assign pop     = q_valid_i && (item.elem || !out_valid_q || !out_stall_i);
  assign q_pop_o = pop;

  assign acc_rd = item.hit ? acc_q[item.idx] : '0;
  assign abs_v  = sat_abs(item.value);

  always_comb begin
    if (use_max) begin
      acc_new = (abs_v > acc_rd) ? abs_v : acc_rd;
    end else if (mode_i == MODE_ABS_SUM) begin
      acc_new = sat_add(acc_rd, abs_v);
    end else begin
      acc_new = sat_add(acc_rd, item.value);
    end
  end

  always_comb begin
    if (use_max) begin
      result = (item.value > acc_rd) ? item.value : acc_rd;
    end else begin
      result = sat_add(item.value, acc_rd);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxBlock; i++) begin
        acc_q[i] <= '0;
      end
    end else if (pop && item.hit) begin
      acc_q[item.idx] <= item.elem ? acc_new : '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop && !item.elem) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && !item.elem) begin
      row_result_q <= result;
      lane_out_q   <= item.lane;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign row_result_o = row_result_q;
  assign lane_out_o   = lane_out_q;

endmodule

`default_nettype wire

// ===== sv/block_csr_row_reduce.sv =====
// Top level of the block-CSR row reducer: register port, front end, queue, back end.
// Depends on bcrr_pkg, bcrr_front, bcrr_fifo and bcrr_back.
`default_nettype none

// The block reduces one block row of a block-CSR matrix into per-lane Q16.16
// results. Matrix values arrive as element beats in storage order, the in-block
// row advancing fastest, so the front end assigns each element to lane
// (k mod blk_rows) without any index from the user. Depending on mode the
// element is added (0), added as an absolute value (1) or merged as a maximum
// absolute value (2 or 3) into that lane's accumulator, with saturation at
// every step. A finish beat carries the prior output value for one lane; the
// block returns prior plus accumulator (sum modes) or the larger of the two
// (max mode) on the output channel, clears that lane and restarts the lane
// position at zero. A lane with no storage reads as zero. The back end
// handles every element or finish beat in one pass, so the block sustains
// one beat per clock while the output is not stalled; a beat reaches a
// visible result through the queue and then the output register. The back
// end does a single read-modify-write of one accumulator per cycle. Registers
// (blk_rows at 0x0, blk_cols at 0x4, mode at 0x8) must be written only
// while the block is idle; blk_cols is stored and read back but does not
// change the results, and writing blk_rows restarts the lane position.

module block_csr_row_reduce #(
  parameter int MaxBlock   = bcrr_pkg::MAX_BLOCK,
  parameter int QueueDepth = bcrr_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic signed [31:0] value_i,
  input  logic [1:0]         lane_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] row_result_o,
  output logic [1:0]         lane_out_o
);
  import bcrr_pkg::*;

  // Lane index width; at least one bit so a single-lane build still has a port.
  localparam int LaneW = (MaxBlock > 1) ? $clog2(MaxBlock) : 1;
  localparam int ItemW = LaneW + 36;

  logic [2:0]       blk_rows_q;
  logic [2:0]       blk_cols_q;
  logic [1:0]       mode_q;
  logic             reg_wr;
  logic [1:0]       reg_idx;
  logic             blk_rows_wr;

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  logic [ItemW-1:0] q_wdata;
  logic [ItemW-1:0] q_rdata;

  // Register port: pready is always high, a write lands on the access cycle.
  assign pready      = 1'b1;
  assign reg_wr      = psel && penable && pwrite;
  assign reg_idx     = paddr[3:2];
  assign blk_rows_wr = reg_wr && (reg_idx == REG_BLK_ROWS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_rows_q <= BLK_ROWS_RST;
      blk_cols_q <= BLK_COLS_RST;
      mode_q     <= MODE_ABS_SUM;
    end else if (reg_wr) begin
      unique case (reg_idx)
        REG_BLK_ROWS: blk_rows_q <= pwdata[2:0];
        REG_BLK_COLS: blk_cols_q <= pwdata[2:0];
        REG_MODE:     mode_q     <= pwdata[1:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BLK_ROWS: prdata = 32'(blk_rows_q);
      REG_BLK_COLS: prdata = 32'(blk_cols_q);
      REG_MODE:     prdata = 32'(mode_q);
      default:      prdata = '0;
    endcase
  end

  // The front end tags each beat with its lane and waits only on a full queue.
  bcrr_front #(
    .MaxBlock(MaxBlock),
    .LaneW   (LaneW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .blk_rows_i   (blk_rows_q),
    .blk_rows_wr_i(blk_rows_wr),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .lane_i       (lane_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_data_o     (q_wdata)
  );

  // The queue decouples acceptance from output back-pressure.
  bcrr_fifo #(
    .Width(ItemW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_valid_o(q_valid),
    .pop_data_o (q_rdata)
  );

  // The back end owns the accumulators and the output register.
  bcrr_back #(
    .MaxBlock(MaxBlock),
    .LaneW   (LaneW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .row_result_o(row_result_o),
    .lane_out_o  (lane_out_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_block_csr_row_reduce.sv =====
// Self-checking testbench for block_csr_row_reduce: it streams element and finish beats,
// predicts every row result and compares it field by field. Depends on bcrr_pkg and
// the block_csr_row_reduce top level only.

module tb_block_csr_row_reduce;
  import bcrr_pkg::*;

  // Run-length and pacing knobs.
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned IDLE_PERCENT  = 30;
  localparam int unsigned PHASE_BEATS   = 100;
  localparam int unsigned PHASES        = 10;

  // One input beat as the block sees it.
  typedef struct packed {
    opcode_e            op;
    logic signed [31:0] value;
    logic [1:0]         lane;
  } beat_t;

  // One row result as the block should return it.
  typedef struct packed {
    logic signed [31:0] row_result;
    logic [1:0]         lane;
  } row_t;

  // Clock, reset and every block input start at known values.
  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [3:0]         paddr        = '0;
  logic [31:0]        pwdata       = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic               opcode_i     = 1'b0;
  logic signed [31:0] value_i      = '0;
  logic [1:0]         lane_i       = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic signed [31:0] row_result_o;
  logic [1:0]         lane_out_o;

  block_csr_row_reduce dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .value_i      (value_i),
    .lane_i       (lane_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .row_result_o (row_result_o),
    .lane_out_o   (lane_out_o)
  );

  // Two time units per period: high for one, low for one.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Beats waiting for the driver, and row results the block still owes us.
  beat_t beats_to_send[$];
  row_t  row_results_due[$];

  // The testbench's own copy of the block's registers and lane accumulators.
  logic [2:0]         cfg_rows = BLK_ROWS_RST;
  logic [2:0]         cfg_cols = BLK_COLS_RST;
  mode_e              cfg_mode = MODE_ABS_SUM;
  logic signed [31:0] lane_sum[MAX_BLOCK];
  int unsigned        next_lane = 0;

  // Bookkeeping shared by the processes below.
  logic        in_beat_taken = 1'b0;
  logic        calm          = 1'b0;
  int unsigned holds_asked   = 0;
  int unsigned holds_done    = 0;
  int unsigned hold_left     = 0;
  int unsigned mismatches    = 0;
  int unsigned beats_taken   = 0;
  int unsigned rows_checked  = 0;
  int unsigned beats_queued  = 0;
  int unsigned reg_writes    = 0;
  int unsigned cycle_count   = 0;

  initial begin
    for (int i = 0; i < MAX_BLOCK; i++) lane_sum[i] = '0;
  end

  // ---------------------------------------------------------------------------
  // Q16.16 arithmetic of the predictor. Everything saturates to the signed
  // 32-bit range, and the magnitude of the most negative value is clamped to
  // the most positive one.
  // ---------------------------------------------------------------------------
  function automatic logic signed [31:0] clamp_q(input longint wide);
    if (wide > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (wide < -64'sd2147483648) return 32'sh8000_0000;
    return wide[31:0];
  endfunction

  function automatic logic signed [31:0] sum_q(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return clamp_q(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] magnitude_q(input logic signed [31:0] a);
    longint wide;
    wide = longint'(a);
    if (wide < 0) wide = -wide;
    return clamp_q(wide);
  endfunction

  // Lanes actually cycled through: a blk_rows of zero acts as one, anything
  // above the storage size acts as the storage size.
  function automatic int unsigned lanes_used();
    if (cfg_rows == 3'd0) return 1;
    if (cfg_rows > MAX_BLOCK) return MAX_BLOCK;
    return cfg_rows;
  endfunction

  // Folds one accepted beat into the predicted state. Elements go to the lane
  // at the current position; a finish combines the prior value with the lane,
  // clears it, restarts the position and yields one row result.
  function automatic bit reduce_beat(input beat_t b, output row_t res);
    int unsigned        lanes;
    int unsigned        p;
    logic signed [31:0] acc;
    logic signed [31:0] mag;
    bit                 use_max;
    use_max = cfg_mode[1];
    res     = '0;
    if (b.op == OP_ELEM) begin
      lanes = lanes_used();
      p     = (next_lane >= lanes) ? 0 : next_lane;
      mag   = magnitude_q(b.value);
      if (use_max) begin
        if (mag > lane_sum[p]) lane_sum[p] = mag;
      end else if (cfg_mode == MODE_ABS_SUM) begin
        lane_sum[p] = sum_q(lane_sum[p], mag);
      end else begin
        lane_sum[p] = sum_q(lane_sum[p], b.value);
      end
      next_lane = (p + 1 >= lanes) ? 0 : p + 1;
      return 1'b0;
    end
    // A lane without storage would read as zero and clear nothing.
    acc = '0;
    if (b.lane < MAX_BLOCK) begin
      acc              = lane_sum[b.lane];
      lane_sum[b.lane] = '0;
    end
    res.row_result = use_max ? ((b.value > acc) ? b.value : acc) : sum_q(b.value, acc);
    res.lane       = b.lane;
    next_lane      = 0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. A beat stays on the port until the monitor has seen it
  // taken; otherwise the next beat is offered unless the sender idles.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_input
    beat_t b;
    if (!(in_valid_i && !in_beat_taken)) begin
      if (beats_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
        b = beats_to_send.pop_front();
        opcode_i   <= b.op;
        value_i    <= b.value;
        lane_i     <= b.lane;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall. A requested hold-off keeps the stall up for a long stretch,
  // counted here; otherwise the receiver stalls at random unless calm.
  always @(negedge clk_i) begin : drive_stall
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      holds_done  <= holds_done + 1;
    end else begin
      out_stall_i <= !calm && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Both channels are sampled at the rising edge: an accepted input
  // beat feeds the predictor, an accepted output beat is checked against the
  // oldest row result due.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch
    beat_t b;
    row_t  want;
    row_t  res;
    in_beat_taken <= in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        b.op    = opcode_e'(opcode_i);
        b.value = value_i;
        b.lane  = lane_i;
        beats_taken++;
        if (reduce_beat(b, res)) row_results_due.push_back(res);
      end
      if (out_valid_o && !out_stall_i) begin
        if (row_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0d] row result %h lane %0d arrived with nothing due",
                     cycle_count, row_result_o, lane_out_o);
        end else begin
          want = row_results_due.pop_front();
          rows_checked++;
          if (row_result_o !== want.row_result || lane_out_o !== want.lane) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0d] row result: expected %h lane %0d, got %h lane %0d",
                       cycle_count, want.row_result, want.lane, row_result_o, lane_out_o);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d row results still due",
               cycle_count, row_results_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic queue_beat(input opcode_e op, input logic signed [31:0] value,
                            input logic [1:0] lane);
    beat_t b;
    b.op    = op;
    b.value = value;
    b.lane  = lane;
    beats_to_send.push_back(b);
    beats_queued++;
  endtask

  // Waits until the sender has nothing left and every row result has come
  // back, then lets elements still in flight settle, since they produce
  // no result to wait for.
  task automatic drain();
    while (beats_to_send.size() != 0 || in_valid_i || row_results_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready. The predicted
  // registers change at the edge at which the block takes the write.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      REG_BLK_ROWS: begin
        cfg_rows  = data[2:0];
        next_lane = 0;
      end
      REG_BLK_COLS: begin
        cfg_cols = data[2:0];
      end
      REG_MODE: begin
        cfg_mode = mode_e'(data[1:0]);
      end
      default: begin
      end
    endcase
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Values lean on the saturation corners and small Q16.16 numbers, with the
  // rest spread over the whole 32-bit range.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      3:       return -32'sd1;
      4, 5:    return $signed($urandom_range(32'h0003_FFFF)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // A well-formed block row: whole stored blocks of rows x cols elements,
  // possibly none, then one finish per lane in use, starting at a random lane.
  task automatic queue_block_row();
    int unsigned lanes;
    int unsigned cols;
    int unsigned blocks;
    int unsigned first;
    lanes  = lanes_used();
    cols   = (cfg_cols == 3'd0) ? 1 : cfg_cols;
    blocks = $urandom_range(3);
    first  = $urandom_range(lanes - 1);
    repeat (lanes * cols * blocks) queue_beat(OP_ELEM, pick_value(), 2'($urandom));
    for (int i = 0; i < lanes; i++)
      queue_beat(OP_FINISH, pick_value(), 2'((first + i) % lanes));
  endtask

  // Register settings of the random phases: every mode, blk_rows from zero
  // to the top of its field, blk_cols at both ends.
  logic [2:0] plan_rows[PHASES] = '{3'd1, 3'd2, 3'd4, 3'd3, 3'd0, 3'd5, 3'd7, 3'd4, 3'd2, 3'd4};
  logic [2:0] plan_cols[PHASES] = '{3'd1, 3'd3, 3'd4, 3'd2, 3'd7, 3'd0, 3'd5, 3'd1, 3'd2, 3'd4};
  mode_e      plan_mode[PHASES] = '{MODE_SUM, MODE_ABS_SUM, MODE_MAX_ABS, MODE_MAX_ALT,
                                    MODE_SUM, MODE_MAX_ABS, MODE_ABS_SUM, MODE_SUM,
                                    MODE_MAX_ALT, MODE_ABS_SUM};

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin : sequence_main
    int unsigned phase_start;
    bit          paused;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: one lane, absolute sum. The most negative element
    // saturates to the most positive magnitude, the accumulator saturates,
    // an empty row finishes with just the prior, and a lane not in use
    // reads zero.
    queue_beat(OP_ELEM,   32'sh7FFF_FFFF, 2'd2);
    queue_beat(OP_ELEM,   32'sh8000_0000, 2'd1);
    queue_beat(OP_FINISH, 32'sh0000_0001, 2'd0);
    queue_beat(OP_FINISH, -32'sd5,        2'd0);
    queue_beat(OP_FINISH, 32'sh8000_0000, 2'd3);
    drain();

    // Four lanes, plain sum: lanes cycle in storage order, lane 0 saturates
    // low and lane 1 saturates high on finish.
    reg_write(REG_BLK_ROWS, 32'd4);
    reg_write(REG_MODE, 32'(MODE_SUM));
    queue_beat(OP_ELEM,   32'sh8000_0000, 2'd3);
    queue_beat(OP_ELEM,   32'sh0001_0000, 2'd0);
    queue_beat(OP_ELEM,   -32'sd1,        2'd1);
    queue_beat(OP_ELEM,   32'sh7FFF_FFFF, 2'd2);
    queue_beat(OP_ELEM,   32'sh8000_0000, 2'd0);
    queue_beat(OP_FINISH, 32'shFFFF_0000, 2'd0);
    queue_beat(OP_FINISH, 32'sh7FFF_FFFF, 2'd1);
    drain();

    // Shrink to two lanes while lanes 2 and 3 still hold sums, then switch
    // to maximum absolute: finishing a lane no longer in use reads what it
    // kept, and a negative prior loses against a larger accumulator.
    reg_write(REG_BLK_ROWS, 32'd2);
    reg_write(REG_MODE, 32'(MODE_MAX_ABS));
    queue_beat(OP_FINISH, 32'sh1234_5678, 2'd3);
    queue_beat(OP_ELEM,   32'shFFFE_0000, 2'd0);
    queue_beat(OP_ELEM,   32'sh8000_0000, 2'd3);
    queue_beat(OP_FINISH, -32'sd1,        2'd0);
    queue_beat(OP_FINISH, 32'sh8000_0000, 2'd1);
    queue_beat(OP_FINISH, 32'sh8000_0000, 2'd2);
    drain();

    // The spare mode code behaves as maximum absolute; blk_cols has no
    // effect, and a blk_rows of zero acts as a single lane.
    reg_write(REG_MODE, 32'(MODE_MAX_ALT));
    reg_write(REG_BLK_COLS, 32'd7);
    queue_beat(OP_ELEM,   32'sd5, 2'd1);
    queue_beat(OP_FINISH, 32'sd3, 2'd0);
    queue_beat(OP_FINISH, 32'sd9, 2'd1);
    drain();
    reg_write(REG_BLK_COLS, 32'd0);
    reg_write(REG_BLK_ROWS, 32'd0);
    queue_beat(OP_ELEM,   32'sd3,         2'd0);
    queue_beat(OP_ELEM,   32'sd4,         2'd3);
    queue_beat(OP_FINISH, 32'sh8000_0000, 2'd0);
    drain();

    // Random phases. Most of the traffic is whole block rows; about one
    // step in five is noise: stray elements and finishes of arbitrary lanes,
    // which leave partial sums behind for the next setting to find.
    for (int ph = 0; ph < PHASES; ph++) begin
      reg_write(REG_BLK_ROWS, {29'($urandom_range(31)), plan_rows[ph]});
      reg_write(REG_BLK_COLS, {29'($urandom_range(31)), plan_cols[ph]});
      reg_write(REG_MODE, {30'($urandom_range(63)), plan_mode[ph]});
      // Phase 2 runs without any idling; phase 5 also holds the receiver off
      // for a long stretch while the sender keeps pushing, so the block fills
      // up and stalls its input.
      calm = (ph == 2 || ph == 5);
      if (ph == 5) holds_asked++;
      phase_start = beats_queued;
      paused      = 1'b0;
      while (beats_queued < phase_start + PHASE_BEATS) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 5))
            queue_beat(opcode_e'($urandom_range(1)), pick_value(), 2'($urandom));
        end else begin
          queue_block_row();
        end
        // Halfway through phase 6 the sender stops until every result is back.
        if (ph == 6 && !paused && beats_queued >= phase_start + PHASE_BEATS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
      drain();
    end
    calm = 1'b0;

    drain();
    mismatches += row_results_due.size();
    $display("Covered %0d input beats and %0d checked row results across %0d register writes,",
             beats_taken, rows_checked, reg_writes);
    $display("all four mode codes, blk_rows from 0 to 7, and a long output hold-off.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bcrr_pkg.sv
sv/bcrr_fifo.sv
sv/bcrr_front.sv
sv/bcrr_back.sv
sv/block_csr_row_reduce.sv
dv/tb_block_csr_row_reduce.sv
